// ===== hw/rtl/vsra_pkg.sv =====
// ----------------------------------------------------------------------------
// vsra_pkg: shared types and constants of the ring allocator
// Position type, allocator state record, request and status codes.
// ----------------------------------------------------------------------------
package vsra_pkg;

	localparam int unsigned POS_W = 17;
	localparam int unsigned START_W = 16;
	localparam int unsigned DEF_MAX_RING_BYTES = 65536;
	localparam logic [POS_W-1:0] RING_SIZE_RESET = 17'h10000;

	typedef logic [POS_W-1:0] pos_t;

	// Three byte offsets that describe the live regions of the ring.
	typedef struct packed {
		pos_t rd;
		pos_t wr;
		pos_t unused;
	} ring_state_t;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_CLEAR   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_SPACE    = 2'd1,
		ST_BAD_RELEASE = 2'd2
	} status_t;

endpackage

// ===== hw/rtl/variable_size_ring_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// variable_size_ring_allocator_unit: contiguous-region ring allocator
// Tracks read, write and unused-end offsets of a byte ring and answers
// allocate, release, clear and no-op requests with one result each.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// request   in         start high, busy low        mode, length
// result    out        done high for one cycle     region_start, status,
//                                                  read_position, write_position,
//                                                  unused_position, is_empty
// config    in         ring_size_we high           ring_size_wdata
//
// A request is taken into an input register at the clock edge where start is
// high. The step logic computes the new positions from the input register, and
// the positions and the result register then update together and raise done.
// One transaction is accepted in every cycle: busy is always low, because the
// positions are updated in the same cycle in which the next request is
// registered. The result cannot be stalled by the receiver.
// Reset (arst_n low) clears all positions and sets the ring size to 65536.
//
module variable_size_ring_allocator_unit #(
	parameter int unsigned MAX_RING_BYTES = vsra_pkg::DEF_MAX_RING_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Request channel.
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  vsra_pkg::pos_t               length,
	// Ring size register.
	input  logic                         ring_size_we,
	input  vsra_pkg::pos_t               ring_size_wdata,
	// Result channel.
	output logic                         done,
	output logic [vsra_pkg::START_W-1:0] region_start,
	output logic [1:0]                   status,
	output vsra_pkg::pos_t               read_position,
	output vsra_pkg::pos_t               write_position,
	output vsra_pkg::pos_t               unused_position,
	output logic                         is_empty
);
	import vsra_pkg::*;

	// Ring size register and its clamp to the largest supported ring.
	pos_t ring_size_q;
	pos_t eff_size;

	// Input register.
	logic       vld_s1;
	logic [1:0] mode_s1;
	pos_t       length_s1;

	// Allocator state.
	ring_state_t state_q;
	ring_state_t state_nxt;

	// Step results.
	logic [START_W-1:0] start_nxt;
	status_t            status_nxt;

	// Result register.
	logic               done_q;
	logic [START_W-1:0] region_start_q;
	status_t            status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= RING_SIZE_RESET;
		end else if (ring_size_we) begin
			ring_size_q <= ring_size_wdata;
		end
	end

	// The register is 17 bits wide, so a limit at or above 2^17 never clamps.
	assign eff_size = (32'(ring_size_q) > MAX_RING_BYTES) ?
	                  POS_W'(MAX_RING_BYTES) : ring_size_q;

	// Capture the request; the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1   <= mode;
			length_s1 <= length;
		end
	end

	vsra_step u_step (
		.cur          (state_q),
		.size         (eff_size),
		.mode         (mode_s1),
		.length       (length_s1),
		.nxt          (state_nxt),
		.region_start (start_nxt),
		.status       (status_nxt)
	);

	// The positions and the result update together at the end of the step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= vld_s1;
			if (vld_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			region_start_q <= start_nxt;
			status_q       <= status_nxt;
		end
	end

	assign busy            = 1'b0;
	assign done            = done_q;
	assign region_start    = region_start_q;
	assign status          = status_q;
	assign read_position   = state_q.rd;
	assign write_position  = state_q.wr;
	assign unused_position = state_q.unused;
	assign is_empty        = (state_q == '0);

`ifndef ASSERT_OFF
	// A result only follows a registered request.
	a_done_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1))
		else $error("result strobe without a registered request");

	// A failed request leaves the positions as they were.
	a_fail_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q != ST_OK) |-> (state_q == $past(state_q)))
		else $error("failed request changed the ring positions");

	// Only a successful request can report a region start.
	a_fail_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q != ST_OK) |-> (region_start_q == '0))
		else $error("failed request reported a region start");

	// The positions move only at the edge that produces a result.
	a_state_moves_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(state_q))
		else $error("ring positions changed without a result");
`endif

endmodule

// ===== hw/rtl/vsra_step.sv =====
// ----------------------------------------------------------------------------
// vsra_step: next-state logic of the ring allocator
// Works out the new positions, the region start and the status for one
// registered request from the current positions and the effective ring size.
// ----------------------------------------------------------------------------
module vsra_step (
	input  vsra_pkg::ring_state_t cur,
	input  vsra_pkg::pos_t        size,
	input  logic [1:0]            mode,
	input  vsra_pkg::pos_t        length,
	output vsra_pkg::ring_state_t nxt,
	output logic [vsra_pkg::START_W-1:0] region_start,
	output vsra_pkg::status_t     status
);
	import vsra_pkg::*;

	logic [POS_W:0] wr_end;      // write position plus length, one bit wider
	pos_t           wr_end_m;
	pos_t           tail_room;
	pos_t           live;
	pos_t           rd_adv;
	pos_t           start_pos;

	assign wr_end    = {1'b0, cur.wr} + {1'b0, length};
	assign wr_end_m  = wr_end[POS_W-1:0];
	assign tail_room = (cur.wr <= size) ? size - cur.wr : '0;
	assign rd_adv    = cur.rd + length;

	always_comb begin
		if (cur.rd <= cur.wr) begin
			live = cur.wr - cur.rd;
		end else if (cur.unused >= cur.rd) begin
			live = cur.unused - cur.rd;
		end else begin
			live = '0;
		end
	end

	always_comb begin
		nxt       = cur;
		status    = ST_OK;
		start_pos = '0;
		unique case (mode)
			MODE_ALLOC: begin
				if (cur.wr == cur.unused) begin
					if (tail_room >= length) begin
						if (cur.rd > cur.wr && {1'b0, cur.rd} < wr_end) begin
							status = ST_NO_SPACE;
						end else begin
							start_pos = cur.wr;
							nxt.wr    = wr_end_m;
							if (cur.rd < wr_end_m) begin
								nxt.unused = wr_end_m;
							end
						end
					end else if (cur.rd >= length) begin
						// Wrap to offset 0; the old write position marks the unused end.
						nxt.unused = cur.wr;
						nxt.wr     = length;
					end else begin
						status = ST_NO_SPACE;
					end
				end else begin
					if (cur.rd < cur.wr || (cur.rd - cur.wr) < length ||
					    tail_room < length) begin
						status = ST_NO_SPACE;
					end else begin
						start_pos = cur.wr;
						nxt.wr    = wr_end_m;
					end
				end
			end
			MODE_RELEASE: begin
				if (length > live) begin
					status = ST_BAD_RELEASE;
				end else if (rd_adv == cur.wr) begin
					nxt = '0;
				end else if (rd_adv == cur.unused) begin
					nxt.rd     = '0;
					nxt.unused = cur.wr;
				end else begin
					nxt.rd = rd_adv;
				end
			end
			MODE_CLEAR: begin
				nxt = '0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign region_start = start_pos[START_W-1:0];

endmodule

// ===== tb/sv/variable_size_ring_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// variable_size_ring_allocator_unit_tb: testbench of the ring allocator
// Sends allocate, release, clear and no-op requests under several ring sizes
// and random sender gaps. Every result is checked field by field against a
// behavioral model of the ring positions kept inside this testbench.
// ----------------------------------------------------------------------------
module variable_size_ring_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vsra_pkg::*;

	// The mode encoding that the block treats as a no-op.
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam logic [31:0] POS_MASK = 32'h1FFFF;
	localparam int unsigned RING_LIMIT = DEF_MAX_RING_BYTES;
	// Cycles without any transaction after which the run is declared hung.
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS = 118;

	// One result of the allocator, as the result ports present it.
	typedef struct packed {
		logic [START_W-1:0] region_start;
		logic [1:0]         status;
		pos_t               rd;
		pos_t               wr;
		pos_t               unused;
		logic               empty;
	} alloc_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          mode;
	pos_t                length;
	logic                ring_size_we;
	pos_t                ring_size_wdata;
	logic                done;
	logic [START_W-1:0]  region_start;
	logic [1:0]          status;
	pos_t                read_position;
	pos_t                write_position;
	pos_t                unused_position;
	logic                is_empty;

	// Model copy of the ring state and of the ring size register.
	logic [31:0] model_rd;
	logic [31:0] model_wr;
	logic [31:0] model_unused;
	logic [31:0] model_ring_size;

	// Results predicted for accepted transactions, oldest first.
	alloc_result_t pending_results[$];
	int unsigned error_count;
	int unsigned stall_cycles;

	variable_size_ring_allocator_unit #(
		.MAX_RING_BYTES(RING_LIMIT)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.length          (length),
		.ring_size_we    (ring_size_we),
		.ring_size_wdata (ring_size_wdata),
		.done            (done),
		.region_start    (region_start),
		.status          (status),
		.read_position   (read_position),
		.write_position  (write_position),
		.unused_position (unused_position),
		.is_empty        (is_empty)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// The ring size in use is the register value capped at the build limit.
	function automatic logic [31:0] ring_bytes();
		return (model_ring_size > RING_LIMIT) ? RING_LIMIT : model_ring_size;
	endfunction

	// Bytes that a release may free: up to the write position when the data
	// is not wrapped, else up to the unused mark (never negative).
	function automatic logic [31:0] live_bytes();
		if (model_rd <= model_wr)
			return model_wr - model_rd;
		return (model_unused >= model_rd) ? model_unused - model_rd : 32'd0;
	endfunction

	// Applies one request to the model state and returns the result it gives.
	function automatic alloc_result_t model_request(input logic [1:0] req_mode,
			input pos_t req_len);
		alloc_result_t r;
		logic [31:0] size;
		logic [31:0] tail_room;
		logic [31:0] rd;
		logic [31:0] wr;
		logic [31:0] un;
		logic [31:0] len;
		logic [31:0] region;
		logic [1:0]  st;
		size = ring_bytes();
		rd = model_rd;
		wr = model_wr;
		un = model_unused;
		len = {15'd0, req_len};
		region = 32'd0;
		st = ST_OK;
		case (req_mode)
			MODE_ALLOC: begin
				tail_room = (wr <= size) ? size - wr : 32'd0;
				if (wr == un) begin
					if (tail_room >= len) begin
						// The tail region must not run over live data above it.
						if (rd > wr && rd < wr + len) begin
							st = ST_NO_SPACE;
						end else begin
							region = wr;
							wr = (wr + len) & POS_MASK;
							if (rd < wr)
								un = wr;
						end
					end else if (rd >= len) begin
						// Wrap to offset 0 and keep the old end as the unused mark.
						region = 32'd0;
						un = wr;
						wr = len;
					end else begin
						st = ST_NO_SPACE;
					end
				end else begin
					// Wrapped: only the gap up to the read position is free.
					if (rd < wr || rd - wr < len || tail_room < len) begin
						st = ST_NO_SPACE;
					end else begin
						region = wr;
						wr = (wr + len) & POS_MASK;
					end
				end
			end
			MODE_RELEASE: begin
				if (len > live_bytes()) begin
					st = ST_BAD_RELEASE;
				end else begin
					rd = (rd + len) & POS_MASK;
					if (rd == un && rd == wr) begin
						rd = 32'd0;
						wr = 32'd0;
						un = 32'd0;
					end else if (rd == un) begin
						un = wr;
						rd = 32'd0;
					end else if (rd == wr) begin
						rd = 32'd0;
						wr = 32'd0;
						un = 32'd0;
					end
				end
			end
			MODE_CLEAR: begin
				rd = 32'd0;
				wr = 32'd0;
				un = 32'd0;
			end
			default: begin
			end
		endcase
		if (st != ST_OK)
			region = 32'd0;
		model_rd = rd;
		model_wr = wr;
		model_unused = un;
		r.region_start = region[START_W-1:0];
		r.status = st;
		r.rd = rd[POS_W-1:0];
		r.wr = wr[POS_W-1:0];
		r.unused = un[POS_W-1:0];
		r.empty = (rd == 32'd0 && wr == 32'd0 && un == 32'd0);
		return r;
	endfunction

	// Drives one request from a falling edge and holds it until the block
	// takes the transaction. Before that, the sender may idle for a while:
	// each cycle it stays idle with the given chance in percent. start stays
	// high on return so back-to-back requests keep it asserted.
	task automatic send_request(input logic [1:0] req_mode, input pos_t req_len,
			input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		mode = req_mode;
		length = req_len;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(model_request(req_mode, req_len));
		@(negedge clk);
	endtask

	// Lowers start and waits until every predicted result has come back.
	task automatic drain_results();
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// The ring size is only written while the block has nothing in flight.
	// A short pause covers the two-stage pipeline after the last result.
	task automatic program_ring_size(input pos_t value);
		drain_results();
		repeat (3) @(negedge clk);
		ring_size_we = 1'b1;
		ring_size_wdata = value;
		@(negedge clk);
		ring_size_we = 1'b0;
		model_ring_size = {15'd0, value};
	endtask

	// Filling the whole ring, wrapping, running full and the release of zero
	// bytes that empties a full ring, all at the reset ring size.
	task automatic test_fill_and_wrap();
		send_request(MODE_ALLOC, 17'd0, 0);
		send_request(MODE_ALLOC, 17'd65536, 0);
		send_request(MODE_ALLOC, 17'd1, 0);
		// The region starts at the ring end, so the reported start wraps to 0.
		send_request(MODE_ALLOC, 17'd0, 0);
		send_request(MODE_RELEASE, 17'h1FFFF, 0);
		send_request(MODE_RELEASE, 17'd100, 0);
		send_request(MODE_ALLOC, 17'd50, 0);
		send_request(MODE_ALLOC, 17'd60, 0);
		send_request(MODE_ALLOC, 17'd50, 0);
		// Read and write positions meet: the live count is zero.
		send_request(MODE_RELEASE, 17'd65436, 0);
		send_request(MODE_RELEASE, 17'd0, 0);
	endtask

	// Clear with a full-scale length, the unknown mode, and a release on an
	// empty ring.
	task automatic test_clear_and_no_op();
		send_request(MODE_ALLOC, 17'd300, 0);
		send_request(MODE_NOP, 17'h1FFFF, 0);
		send_request(MODE_CLEAR, 17'h1FFFF, 0);
		send_request(MODE_RELEASE, 17'd1, 0);
	endtask

	// Ring sizes of zero and one, a size above the build limit, and a size
	// lowered below the current write position.
	task automatic test_ring_size_limits();
		program_ring_size(17'd0);
		send_request(MODE_ALLOC, 17'd0, 0);
		send_request(MODE_ALLOC, 17'd1, 0);
		program_ring_size(17'd1);
		send_request(MODE_ALLOC, 17'd1, 0);
		send_request(MODE_ALLOC, 17'd1, 0);
		send_request(MODE_RELEASE, 17'd1, 0);
		program_ring_size(17'h1FFFF);
		send_request(MODE_ALLOC, 17'd40000, 0);
		program_ring_size(17'd500);
		send_request(MODE_ALLOC, 17'd10, 0);
		send_request(MODE_RELEASE, 17'd40000, 0);
	endtask

	// One random request. Most are allocations sized to the ring and releases
	// within the live data, so the ring keeps filling, wrapping and emptying;
	// the rest are oversize requests, clears, no-ops and raw noise.
	task automatic send_random_request(input int unsigned idle_pct);
		int unsigned pick;
		logic [31:0] size;
		logic [31:0] live;
		logic [31:0] len;
		logic [1:0]  req_mode;
		size = ring_bytes();
		live = live_bytes();
		pick = $urandom_range(99);
		if (pick < 46) begin
			req_mode = MODE_ALLOC;
			if ($urandom_range(9) == 0)
				len = $urandom_range(size + 2, 0);
			else
				len = $urandom_range(size / 4 + 1, 0);
		end else if (pick < 88) begin
			req_mode = MODE_RELEASE;
			case ($urandom_range(9))
				0: len = live + $urandom_range(3, 1);
				1, 2: len = live;
				default: len = $urandom_range(live, 0);
			endcase
		end else if (pick < 91) begin
			req_mode = MODE_CLEAR;
			len = $urandom;
		end else if (pick < 93) begin
			req_mode = MODE_NOP;
			len = $urandom;
		end else begin
			req_mode = 2'($urandom_range(3, 0));
			len = $urandom;
		end
		send_request(req_mode, len[POS_W-1:0], idle_pct);
	endtask

	// Random traffic over a series of ring sizes. The sender first idles
	// now and then, then most of the time, and finally not at all.
	task automatic test_random_traffic();
		pos_t size_value;
		int unsigned idle_pct;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: size_value = 17'h1FFFF;
				1: size_value = POS_W'($urandom_range(64, 16));
				2: size_value = POS_W'($urandom_range(131071, 0));
				3: size_value = 17'd1;
				4: size_value = POS_W'($urandom_range(512, 64));
				5: size_value = POS_W'($urandom_range(40, 16));
				6: size_value = 17'd65536;
				default: size_value = POS_W'($urandom_range(3000, 100));
			endcase
			if (phase < 3)
				idle_pct = 18;
			else if (phase < 6)
				idle_pct = 66;
			else
				idle_pct = 0;
			program_ring_size(size_value);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random_request(idle_pct);
		end
	endtask

	task automatic check_field(input string field_name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= 10)
				$display("Mismatch on %s: expected %0d, got %0d", field_name, want, got);
		end
	endtask

	// Result checker: every strobed result is compared with the oldest
	// prediction. A result with nothing predicted is an error as well.
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("Result transaction with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("region_start", 32'(want.region_start), 32'(region_start));
				check_field("status", 32'(want.status), 32'(status));
				check_field("read_position", 32'(want.rd), 32'(read_position));
				check_field("write_position", 32'(want.wr), 32'(write_position));
				check_field("unused_position", 32'(want.unused), 32'(unused_position));
				check_field("is_empty", 32'(want.empty), 32'(is_empty));
			end
		end
	end

	// Watchdog: any accepted request, result or register write restarts it.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || ring_size_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", stall_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_ALLOC;
		length = '0;
		ring_size_we = 1'b0;
		ring_size_wdata = '0;
		model_ring_size = {15'd0, RING_SIZE_RESET};
		model_rd = 32'd0;
		model_wr = 32'd0;
		model_unused = 32'd0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_fill_and_wrap();
		test_clear_and_no_op();
		test_ring_size_limits();
		test_random_traffic();

		// Let the pipeline run dry before judging the run.
		drain_results();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
